// ----- hw/rtl/ctbpq_pkg.sv -----
// shared types, constants and codes for the credit token bucket priority queue
// no dependencies; imported by every module of the block but ctbpq_ram
package ctbpq_pkg;

    // sizes of the credit size fifo and the token bucket
    localparam int FIFO_DEPTH = 64;
    localparam int FRAC_BITS  = 8;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // field widths
    localparam int KIND_W   = 2;
    localparam int SIZE_W   = 11;
    localparam int STAT_W   = 3;
    localparam int WHOLE_W  = 16;
    localparam int BYTES_W  = 17;
    localparam int TOK_W    = WHOLE_W + FRAC_BITS;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    // stream packing widths
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 48;

    // input kinds
    localparam logic [KIND_W-1:0] KIND_TICK    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ENQUEUE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DEQUEUE = 2'd2;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_ACCEPTED = 3'd0;
    localparam logic [STAT_W-1:0] STAT_DROPPED  = 3'd1;
    localparam logic [STAT_W-1:0] STAT_CREDIT   = 3'd2;
    localparam logic [STAT_W-1:0] STAT_DATA     = 3'd3;
    localparam logic [STAT_W-1:0] STAT_NONE     = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REFILL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 2'd2;

    // configuration reset values
    localparam logic [WHOLE_W-1:0] REFILL_RST = 16'd256;
    localparam logic [WHOLE_W-1:0] MAX_RST    = 16'd2048;
    localparam logic [BYTES_W-1:0] LIMIT_RST  = 17'd4096;

    // controller to datapath commands
    typedef struct packed {
        logic latch;   // capture the incoming transaction
        logic exec;    // apply the captured item to the state
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic has_result;  // captured item produces a result
        logic out_free;    // output register can take a result this cycle
    } t_dp_stat;

endpackage

// ----- hw/rtl/ctbpq_ram.sv -----
// generic single write port, single read port ram with registered read data
// no dependencies; holds the credit size fifo
module ctbpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/ctbpq_ctrl.sv -----
// controller state machine: accepts one transaction, then executes it
// depends on ctbpq_pkg for the command and status structs
module ctbpq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ctbpq_pkg::t_dp_stat i_stat,
    output ctbpq_pkg::t_dp_cmd  o_cmd
);
    import ctbpq_pkg::*;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EXEC
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_accept;
    logic   w_done;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = o_in_ready && i_in_valid;
    // an item with a result waits until the output register is free
    assign w_done     = (r_state == ST_EXEC) && (!i_stat.has_result || i_stat.out_free);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (w_accept) n_state = ST_EXEC;
            ST_EXEC: if (w_done) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd.latch = w_accept;
        o_cmd.exec  = w_done;
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef NO_ASSERTIONS
    // an accepted transaction is executed before the next one is taken
    a_accept_then_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_in_ready)
        else $error("transaction accepted while another is in flight");

    // execution only follows a capture
    a_exec_after_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec && $past(r_state == ST_IDLE) |-> $past(o_cmd.latch))
        else $error("execute without a captured transaction");

    // a result is never produced while the output register is occupied
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec && i_stat.has_result |-> i_stat.out_free)
        else $error("result would overwrite a pending result");
`endif

endmodule

// ----- hw/rtl/ctbpq_dp.sv -----
// datapath: configuration, credit fifo bookkeeping, token bucket, output register
// depends on ctbpq_pkg and ctbpq_ram
module ctbpq_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration writes
    input  logic                              i_cfg_we,
    input  logic [ctbpq_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ctbpq_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // captured item fields
    input  logic [ctbpq_pkg::KIND_W-1:0]      i_kind,
    input  logic [ctbpq_pkg::SIZE_W-1:0]      i_credit_size,
    input  logic                              i_data_waiting,
    // control
    input  ctbpq_pkg::t_dp_cmd                i_cmd,
    output ctbpq_pkg::t_dp_stat               o_stat,
    // result
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [ctbpq_pkg::STAT_W-1:0]      o_status,
    output logic [ctbpq_pkg::SIZE_W-1:0]      o_sent_size,
    output logic [ctbpq_pkg::WHOLE_W-1:0]     o_token_level,
    output logic [ctbpq_pkg::BYTES_W-1:0]     o_queued_bytes
);
    import ctbpq_pkg::*;

    localparam logic [TOK_W-1:0] FRAC_MASK = TOK_W'((64'd1 << FRAC_BITS) - 64'd1);

    // configuration registers
    logic [WHOLE_W-1:0] r_refill;
    logic [WHOLE_W-1:0] r_max;
    logic [BYTES_W-1:0] r_limit;

    // captured item
    logic [KIND_W-1:0]  r_kind;
    logic [SIZE_W-1:0]  r_size;
    logic               r_data;

    // queue and bucket state
    logic [PTR_W-1:0]   r_head;
    logic [PTR_W-1:0]   r_tail;
    logic [CNT_W-1:0]   r_count;
    logic [BYTES_W-1:0] r_bytes;
    logic [TOK_W-1:0]   r_tokens;

    logic [PTR_W-1:0]   n_head;
    logic [PTR_W-1:0]   n_tail;
    logic [CNT_W-1:0]   n_count;
    logic [BYTES_W-1:0] n_bytes;
    logic [TOK_W-1:0]   n_tokens;

    // output register
    logic               r_out_valid;
    logic [STAT_W-1:0]  r_status;
    logic [SIZE_W-1:0]  r_sent;
    logic [WHOLE_W-1:0] r_level;
    logic [BYTES_W-1:0] r_qbytes;

    logic [STAT_W-1:0]  w_status;
    logic [SIZE_W-1:0]  w_sent;
    logic [SIZE_W-1:0]  w_head_size;
    logic               w_we;

    logic [TOK_W:0]     w_sum;
    logic [WHOLE_W:0]   w_sum_whole;
    logic [WHOLE_W-1:0] w_clamped;
    logic [WHOLE_W-1:0] w_whole;
    logic [BYTES_W:0]   w_new_total;
    logic               w_fits;
    logic               w_can_send;

    // credit size fifo, read always at the head
    ctbpq_ram #(
        .WIDTH (SIZE_W),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_tail),
        .i_wdata (r_size),
        .i_raddr (r_head),
        .o_rdata (w_head_size)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_refill <= REFILL_RST;
            r_max    <= MAX_RST;
            r_limit  <= LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_REFILL: r_refill <= i_cfg_data[WHOLE_W-1:0];
                CFG_MAX:    r_max    <= i_cfg_data[WHOLE_W-1:0];
                CFG_LIMIT:  r_limit  <= i_cfg_data[BYTES_W-1:0];
                default:    ;
            endcase
        end
    end

    // capture of the accepted item
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_kind <= i_kind;
            r_size <= i_credit_size;
            r_data <= i_data_waiting;
        end
    end

    // bucket refill with saturation of the whole part
    assign w_sum       = {1'b0, r_tokens} + (TOK_W + 1)'(r_refill);
    assign w_sum_whole = w_sum[TOK_W -: (WHOLE_W + 1)];
    assign w_clamped   = (w_sum_whole > {1'b0, r_max}) ? r_max : w_sum_whole[WHOLE_W-1:0];

    // enqueue and dequeue checks
    assign w_whole     = r_tokens[TOK_W-1 -: WHOLE_W];
    assign w_new_total = {1'b0, r_bytes} + (BYTES_W + 1)'(r_size);
    assign w_fits      = (r_count != CNT_W'(FIFO_DEPTH)) && (w_new_total <= {1'b0, r_limit});
    assign w_can_send  = (r_count != '0) && (w_whole >= WHOLE_W'(w_head_size));

    // next state and result of the captured item
    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_count  = r_count;
        n_bytes  = r_bytes;
        n_tokens = r_tokens;
        w_status = STAT_NONE;
        w_sent   = '0;
        w_we     = 1'b0;
        case (r_kind)
            KIND_TICK: begin
                n_tokens = (TOK_W'(w_clamped) << FRAC_BITS) | (w_sum[TOK_W-1:0] & FRAC_MASK);
            end
            KIND_ENQUEUE: begin
                if (w_fits) begin
                    w_we     = i_cmd.exec;
                    n_tail   = (r_tail == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_tail + 1'b1;
                    n_count  = r_count + 1'b1;
                    n_bytes  = w_new_total[BYTES_W-1:0];
                    w_status = STAT_ACCEPTED;
                end else begin
                    w_status = STAT_DROPPED;
                end
            end
            KIND_DEQUEUE: begin
                if (w_can_send) begin
                    n_tokens = r_tokens - (TOK_W'(w_head_size) << FRAC_BITS);
                    n_head   = (r_head == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_head + 1'b1;
                    n_count  = r_count - 1'b1;
                    n_bytes  = r_bytes - BYTES_W'(w_head_size);
                    w_sent   = w_head_size;
                    w_status = STAT_CREDIT;
                end else if (r_data) begin
                    w_status = STAT_DATA;
                end else begin
                    w_status = STAT_NONE;
                end
            end
            default: ;
        endcase
    end

    // state update on execute
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_tail   <= '0;
            r_count  <= '0;
            r_bytes  <= '0;
            r_tokens <= '0;
        end else if (i_cmd.exec) begin
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_count  <= n_count;
            r_bytes  <= n_bytes;
            r_tokens <= n_tokens;
        end
    end

    // status to the controller
    always_comb begin
        o_stat.has_result = (r_kind == KIND_ENQUEUE) || (r_kind == KIND_DEQUEUE);
        o_stat.out_free   = !r_out_valid || i_out_ready;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.exec && o_stat.has_result) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && o_stat.has_result) begin
            r_status <= w_status;
            r_sent   <= w_sent;
            r_level  <= n_tokens[TOK_W-1 -: WHOLE_W];
            r_qbytes <= n_bytes;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_sent_size    = r_sent;
    assign o_token_level  = r_level;
    assign o_queued_bytes = r_qbytes;

`ifndef NO_ASSERTIONS
    // the entry count stays within the fifo depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(FIFO_DEPTH))
        else $error("fifo entry count beyond depth");

    // an empty queue holds no bytes
    a_empty_no_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == '0 |-> r_bytes == '0)
        else $error("byte total nonzero with empty fifo");

    // an empty queue has head and tail together
    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == '0 |-> r_head == r_tail)
        else $error("pointers apart with empty fifo");
`endif

endmodule

// ----- hw/rtl/credit_token_bucket_priority_queue_core.sv -----
// an accepted transaction is captured, then executed into the output register once it is free
// a new item is taken only once the last one has executed, set by the registered read of the fifo head
// a tick or an unused kind passes through the same capture and execute states and gives no result
// a waiting result sits in the output register while the next item is accepted
// reset (synchronous, active low) empties the fifo, zeroes the bucket and
// restores register defaults; fifo contents are not cleared
module credit_token_bucket_priority_queue_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ctbpq_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ctbpq_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [ctbpq_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // credit_size[10:0],
                                                             // data_waiting[11]
    input  logic [ctbpq_pkg::KIND_W-1:0]      s_axis_tuser,  // kind[1:0]
    // result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [ctbpq_pkg::OUT_DATA_W-1:0]  m_axis_tdata,  // sent_size[10:0],
                                                             // token_level[26:11],
                                                             // queued_bytes[43:27]
    output logic [ctbpq_pkg::STAT_W-1:0]      m_axis_tuser   // status[2:0]
);
    import ctbpq_pkg::*;

    t_dp_cmd            w_cmd;
    t_dp_stat           w_stat;
    logic [SIZE_W-1:0]  w_sent;
    logic [WHOLE_W-1:0] w_level;
    logic [BYTES_W-1:0] w_qbytes;

    // configuration is always taken
    assign o_cfg_ready = 1'b1;

    // controller
    ctbpq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // datapath
    ctbpq_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_kind         (s_axis_tuser),
        .i_credit_size  (s_axis_tdata[SIZE_W-1:0]),
        .i_data_waiting (s_axis_tdata[SIZE_W]),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .o_out_valid    (m_axis_tvalid),
        .i_out_ready    (m_axis_tready),
        .o_status       (m_axis_tuser),
        .o_sent_size    (w_sent),
        .o_token_level  (w_level),
        .o_queued_bytes (w_qbytes)
    );

    // result packing, zero filled to whole bytes
    assign m_axis_tdata = {
        (OUT_DATA_W - SIZE_W - WHOLE_W - BYTES_W)'(0), w_qbytes, w_level, w_sent
    };

endmodule
